[src/cbc_pkg.sv]
package cbc_pkg;

    localparam int RAM_BANKS      = 4;
    localparam int RAM_BANK_BYTES = 8192;
    localparam int MAX_ROM_BANKS  = 512;

    localparam int RAM_DEPTH   = RAM_BANKS * RAM_BANK_BYTES;
    localparam int RAM_AW      = $clog2(RAM_DEPTH);
    localparam int BANK_OFF_W  = $clog2(RAM_BANK_BYTES);
    localparam int ROM_CNT_W   = 10;
    localparam int RAM_CNT_W   = 5;
    localparam int CFG_DATA_W  = 10;
    localparam int ROM_ADDR_W  = 23;

    typedef logic [RAM_AW-1:0] ram_addr_t;

    typedef enum logic [1:0] {
        SRC_ROM   = 2'd0,
        SRC_RAM   = 2'd1,
        SRC_OPEN  = 2'd2,
        SRC_WDONE = 2'd3
    } src_t;

    typedef enum logic [1:0] {
        KIND_ROM_ONLY   = 2'd0,
        KIND_MBC1       = 2'd1,
        KIND_MBC3       = 2'd2,
        KIND_UNSUPPORTED = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CFG_CART_KIND     = 2'd0,
        CFG_ROM_BANK_CNT  = 2'd1,
        CFG_RAM_BANK_CNT  = 2'd2,
        CFG_BATTERY       = 2'd3
    } cfg_idx_t;

    localparam logic [2:0] REGION_RAM_EN   = 3'b000;
    localparam logic [2:0] REGION_ROM_BANK = 3'b001;
    localparam logic [2:0] REGION_RAM_BANK = 3'b010;
    localparam logic [2:0] REGION_MODE     = 3'b011;
    localparam logic [2:0] REGION_CART_RAM = 3'b101;

    localparam logic [3:0] RAM_EN_KEY    = 4'hA;
    localparam logic [6:0] MBC1_BANK_MSK = 7'h1F;
    localparam logic [6:0] MBC3_BANK_MSK = 7'h7F;
    localparam logic [7:0] OPEN_BUS      = 8'hFF;

    typedef struct packed {
        src_t                  src;
        logic [ROM_ADDR_W-1:0] rom_address;
        logic                  ram_rd;
        logic                  ram_wr;
        ram_addr_t             ram_addr;
        logic                  save_pending;
    } cbc_dec_t;

endpackage

[src/cbc_req_if.sv]
interface cbc_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] address;
    logic [7:0]  write_data;

    modport source (output valid, output mode, output address, output write_data, input ready);
    modport sink   (input valid, input mode, input address, input write_data, output ready);
endinterface

[src/cbc_rsp_if.sv]
interface cbc_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic [1:0]  data_src;
    logic [22:0] rom_address;
    logic        save_pending;

    modport source (output valid, output read_data, output data_src, output rom_address,
                    output save_pending, input ready);
    modport sink   (input valid, input read_data, input data_src, input rom_address,
                    input save_pending, output ready);
endinterface

[src/cbc_cfg_if.sv]
interface cbc_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [9:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/cartridge_bank_controller.sv]
// channel | dir | handshake       | word
// req     | in  | valid/ready     | mode, address, write_data
// rsp     | out | valid/ready     | read_data, data_src, rom_address, save_pending
// cfg     | in  | valid/ready     | index, data (ready tied high)
//
// One access per cycle while rsp is not stalled; result passes the RAM read stage, then the output reg.
// The cartridge RAM takes at most one read or write per access.
// After reset the RAM is swept to zero, one byte a cycle, all 32768 bytes, with req.ready low.
// Bank registers update at accept, so the next access sees them at once.
// A stalled rsp backs up the RAM stage, then req.ready drops.
module cartridge_bank_controller (
    input  logic      clk,
    input  logic      rst_n,
    cbc_req_if.sink   req,
    cbc_rsp_if.source rsp,
    cbc_cfg_if.sink   cfg
);
    import cbc_pkg::*;

    cbc_dec_t dec;
    logic     req_fire;

    logic      clearing_reg;
    ram_addr_t clear_cnt_reg;

    logic [7:0] mem [RAM_DEPTH];
    logic       mem_we;
    ram_addr_t  mem_waddr;
    logic [7:0] mem_wdata;
    logic [7:0] mem_rdata_reg;

    logic                  s1_valid_reg, s1_valid_next;
    src_t                  s1_src_reg;
    logic [ROM_ADDR_W-1:0] s1_rom_addr_reg;
    logic                  s1_save_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_rdata_reg;
    src_t                  out_src_reg;
    logic [ROM_ADDR_W-1:0] out_rom_addr_reg;
    logic                  out_save_reg;

    logic out_load;
    logic s1_free;

    cbc_bank_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .fire       (req_fire),
        .mode       (req.mode),
        .address    (req.address),
        .write_data (req.write_data),
        .dec        (dec)
    );

    assign out_load  = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign s1_free   = !s1_valid_reg || out_load;
    assign req.ready = !clearing_reg && s1_free;
    assign req_fire  = req.valid && req.ready;

    assign s1_valid_next  = req_fire || (s1_valid_reg && !out_load);
    assign out_valid_next = out_load || (out_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clear_cnt_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clear_cnt_reg <= clear_cnt_reg + RAM_AW'(1);
            if (clear_cnt_reg == RAM_AW'(RAM_DEPTH - 1))
                clearing_reg <= 1'b0;
        end
    end

    assign mem_we    = clearing_reg || (req_fire && dec.ram_wr);
    assign mem_waddr = clearing_reg ? clear_cnt_reg : dec.ram_addr;
    assign mem_wdata = clearing_reg ? 8'd0 : req.write_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (req_fire && dec.ram_rd)
            mem_rdata_reg <= mem[dec.ram_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_src_reg      <= dec.src;
            s1_rom_addr_reg <= dec.rom_address;
            s1_save_reg     <= dec.save_pending;
        end
        if (out_load)
        begin
            out_src_reg      <= s1_src_reg;
            out_rom_addr_reg <= s1_rom_addr_reg;
            out_save_reg     <= s1_save_reg;
            case (s1_src_reg)
                SRC_RAM:  out_rdata_reg <= mem_rdata_reg;
                SRC_OPEN: out_rdata_reg <= OPEN_BUS;
                default:  out_rdata_reg <= 8'd0;
            endcase
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.read_data    = out_rdata_reg;
    assign rsp.data_src     = out_src_reg;
    assign rsp.rom_address  = out_rom_addr_reg;
    assign rsp.save_pending = out_save_reg;

`ifndef SYNTHESIS
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !req_fire)
        else $error("access accepted during RAM sweep");

    a_ram_write_is_write: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && dec.ram_wr) |-> (dec.src == SRC_WDONE && !dec.ram_rd))
        else $error("RAM write decoded on a read access");

    a_ram_read_src: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && dec.ram_rd) |=> (s1_valid_reg && s1_src_reg == SRC_RAM))
        else $error("RAM read not tracked in RAM stage");

    a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clearing_reg) |-> $past(clear_cnt_reg) == RAM_AW'(RAM_DEPTH - 1))
        else $error("RAM sweep ended early");

    a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_src_reg == SRC_RAM && !out_load)
            |=> (s1_valid_reg && $stable(mem_rdata_reg)))
        else $error("RAM stage lost its data while blocked");
`endif

endmodule

[src/cbc_bank_regs.sv]
module cbc_bank_regs (
    input  logic             clk,
    input  logic             rst_n,
    cbc_cfg_if.sink          cfg,
    input  logic             fire,
    input  logic             mode,
    input  logic [15:0]      address,
    input  logic [7:0]       write_data,
    output cbc_pkg::cbc_dec_t dec
);
    import cbc_pkg::*;

    kind_t                kind_reg;
    logic [ROM_CNT_W-1:0] rom_cnt_reg;
    logic [RAM_CNT_W-1:0] ram_cnt_reg;
    logic                 battery_reg;

    logic       ram_en_reg,   ram_en_next;
    logic [6:0] rom_bank_reg, rom_bank_next;
    logic [1:0] ram_sel_reg,  ram_sel_next;
    logic [1:0] act_bank_reg, act_bank_next;
    logic       bmode_reg,    bmode_next;
    logic       dirty_reg,    dirty_next;

    logic                 banked;
    logic [ROM_CNT_W-1:0] rom_lim;
    logic [RAM_CNT_W-1:0] ram_lim;
    logic                 ram_ok;
    logic [6:0]           sw_bank;
    logic [6:0]           masked_bank;
    logic [2:0]           region;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg    <= KIND_ROM_ONLY;
            rom_cnt_reg <= ROM_CNT_W'(2);
            ram_cnt_reg <= '0;
            battery_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_CART_KIND:    kind_reg    <= kind_t'(cfg.data[1:0]);
                CFG_ROM_BANK_CNT: rom_cnt_reg <= cfg.data[ROM_CNT_W-1:0];
                CFG_RAM_BANK_CNT: ram_cnt_reg <= cfg.data[RAM_CNT_W-1:0];
                CFG_BATTERY:      battery_reg <= cfg.data[0];
                default:          battery_reg <= battery_reg;
            endcase
        end
    end

    assign banked  = (kind_reg == KIND_MBC1) || (kind_reg == KIND_MBC3);
    assign rom_lim = (rom_cnt_reg < ROM_CNT_W'(MAX_ROM_BANKS)) ? rom_cnt_reg
                                                               : ROM_CNT_W'(MAX_ROM_BANKS);
    assign ram_lim = (ram_cnt_reg < RAM_CNT_W'(RAM_BANKS)) ? ram_cnt_reg
                                                           : RAM_CNT_W'(RAM_BANKS);
    assign ram_ok  = ram_en_reg && (RAM_CNT_W'(act_bank_reg) < ram_lim);
    assign sw_bank = banked ? rom_bank_reg : 7'd1;
    assign region  = address[15:13];
    assign masked_bank = write_data[6:0]
                       & ((kind_reg == KIND_MBC1) ? MBC1_BANK_MSK : MBC3_BANK_MSK);

    always_comb
    begin
        ram_en_next   = ram_en_reg;
        rom_bank_next = rom_bank_reg;
        ram_sel_next  = ram_sel_reg;
        act_bank_next = act_bank_reg;
        bmode_next    = bmode_reg;
        dirty_next    = dirty_reg;

        dec.src          = SRC_OPEN;
        dec.rom_address  = '0;
        dec.ram_rd       = 1'b0;
        dec.ram_wr       = 1'b0;
        dec.ram_addr     = RAM_AW'({act_bank_reg, address[BANK_OFF_W-1:0]});
        dec.save_pending = dirty_reg;

        if (mode)
        begin
            dec.src = SRC_WDONE;
            if (banked)
            begin
                case (region)
                    REGION_RAM_EN:
                        ram_en_next = (write_data[3:0] == RAM_EN_KEY);
                    REGION_ROM_BANK:
                        rom_bank_next = (masked_bank == 7'd0) ? 7'd1 : masked_bank;
                    REGION_RAM_BANK:
                    begin
                        ram_sel_next = write_data[1:0];
                        if (kind_reg == KIND_MBC3 || bmode_reg)
                            act_bank_next = write_data[1:0];
                    end
                    REGION_MODE:
                    begin
                        if (kind_reg == KIND_MBC1)
                        begin
                            bmode_next = write_data[0];
                            if (write_data[0])
                                act_bank_next = ram_sel_reg;
                        end
                    end
                    REGION_CART_RAM:
                    begin
                        if (ram_ok)
                        begin
                            dec.ram_wr = 1'b1;
                            if (battery_reg)
                                dirty_next = 1'b1;
                        end
                    end
                    default:
                        dec.src = SRC_WDONE;
                endcase
            end
            dec.save_pending = dirty_next;
        end
        else
        begin
            case (address[15:14])
                2'b00:
                begin
                    if (rom_lim != '0)
                    begin
                        dec.src         = SRC_ROM;
                        dec.rom_address = ROM_ADDR_W'(address[13:0]);
                    end
                end
                2'b01:
                begin
                    if (kind_reg != KIND_UNSUPPORTED && ROM_CNT_W'(sw_bank) < rom_lim)
                    begin
                        dec.src         = SRC_ROM;
                        dec.rom_address = ROM_ADDR_W'({sw_bank, address[13:0]});
                    end
                end
                default:
                begin
                    if (region == REGION_CART_RAM && banked && ram_ok)
                    begin
                        dec.src    = SRC_RAM;
                        dec.ram_rd = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_en_reg   <= 1'b0;
            rom_bank_reg <= 7'd1;
            ram_sel_reg  <= 2'd0;
            act_bank_reg <= 2'd0;
            bmode_reg    <= 1'b0;
            dirty_reg    <= 1'b0;
        end
        else if (fire)
        begin
            ram_en_reg   <= ram_en_next;
            rom_bank_reg <= rom_bank_next;
            ram_sel_reg  <= ram_sel_next;
            act_bank_reg <= act_bank_next;
            bmode_reg    <= bmode_next;
            dirty_reg    <= dirty_next;
        end
    end

endmodule
